FILE: src/fpa_pkg.sv
// Shared types, constants and helper functions for the fixed-point ALU.
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DIV_BITS = 32 + FRAC_BITS;
   localparam logic [63:0] ROUND_HALF = (64'(1) << FRAC_BITS) >> 1;
   localparam logic signed [63:0] WIDE_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] WIDE_MIN = -64'sh0000_0000_8000_0000;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_LT      = 4'd4,
      OP_GT      = 4'd5,
      OP_EQ      = 4'd6,
      OP_GE      = 4'd7,
      OP_LE      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        neg;
      logic        div_zero;
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic [31:0] value;
      logic        cmp;
      status_type  status;
   } item_type;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
   } sat_type;

   function automatic sat_type saturate(input logic [63:0] mag, input logic neg);
      sat_type res;
      res.status = ST_OK;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) begin
            res.value = 32'h8000_0000;
            res.status = ST_OVF;
         end else begin
            res.value = 32'(~mag[31:0] + 32'd1);
         end
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            res.value = 32'h7FFF_FFFF;
            res.status = ST_OVF;
         end else begin
            res.value = mag[31:0];
         end
      end
      return res;
   endfunction

   function automatic sat_type clamp33(input logic signed [32:0] sum);
      sat_type res;
      res.status = ST_OK;
      if (sum[32] != sum[31]) begin
         res.value = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         res.status = ST_OVF;
      end else begin
         res.value = sum[31:0];
      end
      return res;
   endfunction

endpackage

FILE: src/fpa_front.sv
// Front stage: accepts request beats, computes simple operations and classifies the rest.
module fpa_front import fpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               push,
   output item_type           push_item,
   input  logic               queue_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   logic signed [32:0] sum_ab, diff_ab, sum_inc, sum_dec;
   logic signed [63:0] wide_a;
   sat_type            sat;

   assign req_stall = valid_ff && queue_full;
   assign push = valid_ff && !queue_full;
   assign push_item = item_ff;

   always_comb begin
      sum_ab  = 33'(req_operand_a) + 33'(req_operand_b);
      diff_ab = 33'(req_operand_a) - 33'(req_operand_b);
      sum_inc = 33'(req_operand_a) + 33'sd1;
      sum_dec = 33'(req_operand_a) - 33'sd1;
      wide_a  = 64'(req_operand_a) <<< FRAC_BITS;
      sat.value = 32'd0;
      sat.status = ST_OK;
      item_in.kind = KIND_SIMPLE;
      item_in.neg = req_operand_a[31] != req_operand_b[31];
      item_in.div_zero = req_operand_b == 32'sd0;
      item_in.mag_a = req_operand_a[31] ? 32'(-req_operand_a) : req_operand_a;
      item_in.mag_b = req_operand_b[31] ? 32'(-req_operand_b) : req_operand_b;
      item_in.cmp = 1'b0;
      unique case (opcode_type'(req_opcode))
         OP_ADD: sat = clamp33(sum_ab);
         OP_SUB: sat = clamp33(diff_ab);
         OP_MUL: item_in.kind = KIND_MUL;
         OP_DIV: item_in.kind = KIND_DIV;
         OP_LT: item_in.cmp = req_operand_a < req_operand_b;
         OP_GT: item_in.cmp = req_operand_a > req_operand_b;
         OP_EQ: item_in.cmp = req_operand_a == req_operand_b;
         OP_GE: item_in.cmp = req_operand_a >= req_operand_b;
         OP_LE: item_in.cmp = req_operand_a <= req_operand_b;
         OP_NE: item_in.cmp = req_operand_a != req_operand_b;
         OP_MIN: sat.value = (req_operand_a < req_operand_b) ? req_operand_a : req_operand_b;
         OP_MAX: sat.value = (req_operand_a > req_operand_b) ? req_operand_a : req_operand_b;
         OP_INC: sat = clamp33(sum_inc);
         OP_DEC: sat = clamp33(sum_dec);
         OP_TOINT: sat.value = req_operand_a >>> FRAC_BITS;
         OP_FROMINT: begin
            if (wide_a > WIDE_MAX) begin
               sat.value = 32'h7FFF_FFFF;
               sat.status = ST_OVF;
            end else if (wide_a < WIDE_MIN) begin
               sat.value = 32'h8000_0000;
               sat.status = ST_OVF;
            end else begin
               sat.value = wide_a[31:0];
            end
         end
         default: item_in.kind = KIND_SIMPLE;
      endcase
      item_in.value = sat.value;
      item_in.status = sat.status;
      valid_in = req_stall ? valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!req_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: src/fpa_queue.sv
// Two-entry queue between the front stage and the arithmetic back end.
module fpa_queue import fpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   item_type   mem_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/fpa_back.sv
// Back end: pipelined multiplier and one-bit-per-stage divider with the result register.
module fpa_back import fpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  item_type    head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_value,
   output logic        rsp_compare_true,
   output logic [1:0]  rsp_status
);

   typedef struct packed {
      item_type              item;
      logic [32:0]           rem;
      logic [DIV_BITS-1:0]   dq;
      logic [63:0]           prod;
   } stage_type;

   stage_type   st_ff [0:DIV_BITS];
   stage_type   st_in [0:DIV_BITS];
   logic        vld_ff [0:DIV_BITS];
   logic        out_valid_ff;
   logic [31:0] out_value_ff, out_value_in;
   logic        out_cmp_ff;
   status_type  out_status_ff, out_status_in;
   logic        advance;
   logic [32:0] shifted;
   logic        ge;
   sat_type     sat;

   assign advance = !out_valid_ff || !rsp_stall;
   assign pop = advance && !queue_empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_compare_true = out_cmp_ff;
   assign rsp_status = out_status_ff;

   always_comb begin
      st_in[0].item = head;
      st_in[0].rem = 33'd0;
      st_in[0].dq = {head.mag_a, {FRAC_BITS{1'b0}}};
      st_in[0].prod = 64'(head.mag_a) * 64'(head.mag_b);
      for (int k = 0; k < DIV_BITS; k++) begin
         shifted = {st_ff[k].rem[31:0], st_ff[k].dq[DIV_BITS-1]};
         ge = shifted >= {1'b0, st_ff[k].item.mag_b};
         st_in[k+1].item = st_ff[k].item;
         st_in[k+1].rem = ge ? 33'(shifted - {1'b0, st_ff[k].item.mag_b}) : shifted;
         st_in[k+1].dq = {st_ff[k].dq[DIV_BITS-2:0], ge};
         st_in[k+1].prod = (k == 0) ? st_ff[k].prod + ROUND_HALF : st_ff[k].prod;
      end
   end

   always_comb begin
      sat.value = st_ff[DIV_BITS].item.value;
      sat.status = st_ff[DIV_BITS].item.status;
      unique case (st_ff[DIV_BITS].item.kind)
         KIND_MUL: sat = saturate(st_ff[DIV_BITS].prod >> FRAC_BITS, st_ff[DIV_BITS].item.neg);
         KIND_DIV: begin
            if (st_ff[DIV_BITS].item.div_zero) begin
               sat.value = 32'd0;
               sat.status = ST_DZ;
            end else begin
               sat = saturate(64'(st_ff[DIV_BITS].dq), st_ff[DIV_BITS].item.neg);
            end
         end
         default: sat.value = st_ff[DIV_BITS].item.value;
      endcase
      out_value_in = sat.value;
      out_status_in = sat.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_BITS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         out_valid_ff <= vld_ff[DIV_BITS];
         vld_ff[0] <= !queue_empty;
         for (int k = 1; k <= DIV_BITS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      if (advance) begin
         for (int k = 0; k <= DIV_BITS; k++) begin
            st_ff[k] <= st_in[k];
         end
         out_value_ff <= out_value_in;
         out_cmp_ff <= st_ff[DIV_BITS].item.cmp;
         out_status_ff <= out_status_in;
      end
   end

endmodule

FILE: src/fixed_point_alu.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Each beat passes the front register, the queue, 41 back-end stages and the output register.
// One beat per cycle for any opcode when not stalled; the divider retires one quotient bit per stage.
// The back end stalls as a whole only while a result waits on rsp_stall.
// Synchronous reset empties the front register, the queue and every pipeline stage.
module fixed_point_alu import fpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_compare_true,
   output logic [1:0]         rsp_status
);

   logic     push, queue_full, pop, queue_empty;
   item_type push_item, head;

   fpa_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .push(push), .push_item(push_item), .queue_full(queue_full)
   );

   fpa_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_item(push_item), .full(queue_full),
      .pop(pop), .empty(queue_empty), .head(head)
   );

   fpa_back u_back (
      .clock(clock), .reset(reset),
      .queue_empty(queue_empty), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value), .rsp_compare_true(rsp_compare_true),
      .rsp_status(rsp_status)
   );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the Q24.8 fixed-point ALU with random stimulus and stalls.
`timescale 1ns / 1ps

module testbench import fpa_pkg::*; ();

   typedef struct {
      logic signed [31:0] value;
      logic               cmp;
      logic [1:0]         status;
   } alu_result_type;

   class alu_scoreboard;
      alu_result_type pending[$];
      int errors = 0;

      function logic signed [31:0] clamp_wide(input logic signed [63:0] v,
                                              inout logic [1:0] st);
         if (v > WIDE_MAX) begin
            st = ST_OVF;
            return 32'h7FFF_FFFF;
         end
         if (v < WIDE_MIN) begin
            st = ST_OVF;
            return 32'h8000_0000;
         end
         return v[31:0];
      endfunction

      function void note_request(input opcode_type op, input logic signed [31:0] a,
                                 input logic signed [31:0] b);
         alu_result_type r;
         logic signed [63:0] wa, wb;
         logic [63:0] ma, mb, prod, quot;
         logic neg;
         wa = a;
         wb = b;
         ma = wa < 0 ? -wa : wa;
         mb = wb < 0 ? -wb : wb;
         neg = (wa < 0) != (wb < 0);
         r.value = 0;
         r.cmp = 0;
         r.status = ST_OK;
         case (op)
            OP_ADD: r.value = clamp_wide(wa + wb, r.status);
            OP_SUB: r.value = clamp_wide(wa - wb, r.status);
            OP_MUL: begin
               prod = (ma * mb + ROUND_HALF) >> FRAC_BITS;
               r.value = clamp_wide(neg ? -$signed(prod) : $signed(prod), r.status);
            end
            OP_DIV: begin
               if (b == 0) r.status = ST_DZ;
               else begin
                  quot = (ma << FRAC_BITS) / mb;
                  r.value = clamp_wide(neg ? -$signed(quot) : $signed(quot), r.status);
               end
            end
            OP_LT: r.cmp = a < b;
            OP_GT: r.cmp = a > b;
            OP_EQ: r.cmp = a == b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.value = a < b ? a : b;
            OP_MAX: r.value = a > b ? a : b;
            OP_INC: r.value = clamp_wide(wa + 1, r.status);
            OP_DEC: r.value = clamp_wide(wa - 1, r.status);
            OP_TOINT: r.value = a >>> FRAC_BITS;
            default: r.value = clamp_wide(wa <<< FRAC_BITS, r.status);
         endcase
         pending.push_back(r);
      endfunction

      function void check_response(input logic signed [31:0] value, input logic cmp,
                                   input logic [1:0] status);
         alu_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat: value %h", value);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) begin
            $error("result_value: expected %h, actual %h", e.value, value);
            errors++;
         end
         if (cmp !== e.cmp) begin
            $error("compare_true: expected %b, actual %b", e.cmp, cmp);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_opcode;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               rsp_compare_true;
   logic [1:0]         rsp_status;

   alu_scoreboard board = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   fixed_point_alu uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_request(opcode_type'(req_opcode), req_operand_a, req_operand_b);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_result_value, rsp_compare_true, rsp_status);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF - $urandom_range(3);
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return $urandom_range(2) - 1;
         3: return $signed($urandom_range(4095)) - 2048;
         4: return $signed($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input opcode_type op, input logic [31:0] a,
                               input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      logic [31:0] a;
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         a = pick_operand();
         send_request(opcode_type'($urandom_range(15)),
                      a, ($urandom_range(7) == 0) ? a : pick_operand());
      end
      req_valid <= 0;
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_opcode = OP_ADD;
      req_operand_a = 0;
      req_operand_b = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
      send_request(OP_SUB, 32'h8000_0000, 32'h0000_0001);
      send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send_request(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001);
      send_request(OP_MUL, 32'h0000_0080, 32'h0000_0001);
      send_request(OP_DIV, 32'h0000_0100, 32'h0000_0000);
      send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_DIV, 32'hFFFF_FD00, 32'h0000_0200);
      send_request(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_GT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_EQ, 32'h1234_5678, 32'h1234_5678);
      send_request(OP_GE, 32'h0000_0005, 32'h0000_0005);
      send_request(OP_LE, 32'h0000_0006, 32'h0000_0005);
      send_request(OP_NE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_MIN, 32'h0000_0007, 32'h0000_0007);
      send_request(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_INC, 32'h7FFF_FFFF, 32'h0);
      send_request(OP_DEC, 32'h8000_0000, 32'h0);
      send_request(OP_TOINT, 32'hFFFF_FF01, 32'hFFFF_FFFF);
      send_request(OP_TOINT, 32'h7FFF_FFFF, 32'h0);
      send_request(OP_FROMINT, 32'h0080_0000, 32'h0);
      send_request(OP_FROMINT, 32'hFF7F_FFFF, 32'h0);
      send_request(OP_FROMINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(0, 0, 350);
      run_phase(76, 0, 350);
      run_phase(0, 76, 350);
      run_phase(38, 38, 350);
      stall_pct = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
